/* design/bda_pkg.sv */
// ----------------------------------------------------------------------------
// Button debounce package
// Shared widths, reset values, register indexes and types of the button
// debouncer with auto-repeat.
// ----------------------------------------------------------------------------
package bda_pkg;

    localparam int NUM_BUTTONS  = 4;
    localparam int FIELD_W      = 4;
    localparam int TIME_W       = 32;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 8;

    localparam logic [CFG_W-1:0]   DEBOUNCE_RESET      = 16'd50;
    localparam logic [CFG_W-1:0]   REPEAT_DELAY_RESET  = 16'd400;
    localparam logic [CFG_W-1:0]   REPEAT_PERIOD_RESET = 16'd120;
    localparam logic [FIELD_W-1:0] REPEAT_MASK_RESET   = 4'd3;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MASK   = 2'd3;

    // Timing settings that every lane sees.
    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] repeat_delay;
        logic [CFG_W-1:0] repeat_period;
    } t_timing;

    // What one lane reports for the current item.
    typedef struct packed {
        logic fire;
        logic level;
    } t_lane_out;

endpackage

/* design/bda_lane.sv */
// ----------------------------------------------------------------------------
// Button debounce lane
// Debounce filter and auto-repeat timer of one button, updated per item.
// ----------------------------------------------------------------------------
module bda_lane
    import bda_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic              i_raw,
    input  logic              i_repeat_on,
    input  t_timing           i_timing,
    output t_lane_out         o_result
);

    logic              r_filt, n_filt;
    logic              r_prev;
    logic [TIME_W-1:0] r_change, n_change;
    logic [TIME_W-1:0] r_first, n_first;
    logic [TIME_W-1:0] r_last, n_last;

    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] since_first;
    logic [TIME_W-1:0] since_last;
    logic              stable;
    logic              press;
    logic              rep;

    always_comb begin
        n_change     = (i_raw != r_prev) ? i_now_ms : r_change;
        since_change = i_now_ms - n_change;
        since_first  = i_now_ms - r_first;
        since_last   = i_now_ms - r_last;
        stable       = since_change >= {{(TIME_W-CFG_W){1'b0}}, i_timing.debounce_time};
        press        = stable && i_raw && !r_filt;
        n_filt       = stable ? i_raw : r_filt;
        // A press pulse takes the place of a repeat check in the same item.
        rep          = stable && i_repeat_on && n_filt && !press
                       && (since_first >= {{(TIME_W-CFG_W){1'b0}}, i_timing.repeat_delay})
                       && (since_last >= {{(TIME_W-CFG_W){1'b0}}, i_timing.repeat_period});
        n_first      = press ? i_now_ms : r_first;
        n_last       = (press || rep) ? i_now_ms : r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt   <= 1'b0;
            r_prev   <= 1'b0;
            r_change <= '0;
            r_first  <= '0;
            r_last   <= '0;
        end else if (i_accept) begin
            r_filt   <= n_filt;
            r_prev   <= i_raw;
            r_change <= n_change;
            r_first  <= n_first;
            r_last   <= n_last;
        end
    end

    assign o_result.fire  = press || rep;
    assign o_result.level = n_filt;

endmodule

/* design/bda_merge.sv */
// ----------------------------------------------------------------------------
// Button debounce merge stage
// Gathers the lane results into one result item and holds it in an output
// register with a skid entry behind it.
// ----------------------------------------------------------------------------
module bda_merge
    import bda_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  t_lane_out [NUM_BUTTONS-1:0] i_lanes,
    output logic                   o_in_ready,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [OUT_TDATA_W-1:0] o_data
);

    logic [FIELD_W-1:0]     fire_field;
    logic [FIELD_W-1:0]     level_field;
    logic [OUT_TDATA_W-1:0] new_data;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_skid_valid;
    logic [OUT_TDATA_W-1:0] r_skid_data;
    logic                   out_take;

    // Buttons past the field width do not appear; missing buttons read zero.
    for (genvar g = 0; g < FIELD_W; g++) begin : g_field
        if (g < NUM_BUTTONS) begin : g_have
            assign fire_field[g]  = i_lanes[g].fire;
            assign level_field[g] = i_lanes[g].level;
        end else begin : g_none
            assign fire_field[g]  = 1'b0;
            assign level_field[g] = 1'b0;
        end
    end

    assign new_data = {level_field, fire_field};
    assign out_take = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                if (!r_out_valid || out_take) begin
                    r_out_valid <= 1'b1;
                    r_out_data  <= new_data;
                end else begin
                    r_skid_valid <= 1'b1;
                    r_skid_data  <= new_data;
                end
            end else if (out_take) begin
                if (r_skid_valid) begin
                    r_out_data   <= r_skid_data;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    assign o_in_ready = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out_data;

endmodule

/* design/button_debounce_autorepeat.sv */
// ----------------------------------------------------------------------------
// Button debouncer with auto-repeat
// Debounces four buttons from timestamped samples and emits press and
// repeat pulses together with the debounced levels.
//
//   Channel   Direction  Item fields (lowest bit first)
//   s_axis    in         now_ms[31:0], raw_pressed[35:32], zero pad [39:36]
//   m_axis    out        fire_mask[3:0], filtered_mask[7:4]
//   cfg       in         write enable, register index, 16-bit data
//
// One item per cycle is accepted while input ready is high; its result is
// registered on acceptance. Every button lane does its three 32-bit subtracts
// and compares in the accept cycle, which sets the cycle time.
// Reset is synchronous and restores the register defaults and clears all
// button state. A stalled output keeps one more result in a skid entry;
// input ready drops only while that entry is occupied.
// ----------------------------------------------------------------------------
module button_debounce_autorepeat
    import bda_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // now_ms[31:0], raw_pressed[35:32], zero [39:36]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // fire_mask[3:0], filtered_mask[7:4]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    t_timing            r_timing;
    logic [FIELD_W-1:0] r_repeat_mask;

    logic                        accept;
    logic [TIME_W-1:0]           now_ms;
    logic [FIELD_W-1:0]          raw_pressed;
    t_lane_out [NUM_BUTTONS-1:0] lanes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.debounce_time <= DEBOUNCE_RESET;
            r_timing.repeat_delay  <= REPEAT_DELAY_RESET;
            r_timing.repeat_period <= REPEAT_PERIOD_RESET;
            r_repeat_mask          <= REPEAT_MASK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DEBOUNCE_TIME: r_timing.debounce_time <= i_cfg_data;
                REG_REPEAT_DELAY:  r_timing.repeat_delay  <= i_cfg_data;
                REG_REPEAT_PERIOD: r_timing.repeat_period <= i_cfg_data;
                REG_REPEAT_MASK:   r_repeat_mask          <= i_cfg_data[FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    assign accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign now_ms      = i_s_axis_tdata[TIME_W-1:0];
    assign raw_pressed = i_s_axis_tdata[TIME_W +: FIELD_W];

    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
        logic raw_bit;
        logic rep_bit;
        // Buttons past the field width read released and never repeat.
        if (b < FIELD_W) begin : g_in
            assign raw_bit = raw_pressed[b];
            assign rep_bit = r_repeat_mask[b];
        end else begin : g_out
            assign raw_bit = 1'b0;
            assign rep_bit = 1'b0;
        end

        bda_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_accept    (accept),
            .i_now_ms    (now_ms),
            .i_raw       (raw_bit),
            .i_repeat_on (rep_bit),
            .i_timing    (r_timing),
            .o_result    (lanes[b])
        );
    end

    bda_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_lanes    (lanes),
        .o_in_ready (o_s_axis_tready),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_data     (o_m_axis_tdata)
    );

endmodule

/* design/bda_checker.sv */
// ----------------------------------------------------------------------------
// Button debounce port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module bda_checker
    import bda_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // A pulse only comes with a pressed debounced level.
    a_fire_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tdata[3:0] & ~o_m_axis_tdata[7:4]) == 4'd0))
        else $error("fire without pressed level");

    // Input stalls only while a result is waiting.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with empty output");

    // After an accepted item the output is valid in the next cycle.
    a_item_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> o_m_axis_tvalid)
        else $error("accepted item not presented");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind button_debounce_autorepeat bda_checker u_bda_checker (.*);

/* sim/bda_result_monitor.sv */
// ----------------------------------------------------------------------------
// Button debounce result monitor
// Watches the sample, result and register write ports of the debouncer,
// keeps its own model of every button lane and of the timing registers,
// predicts the fire and filtered masks of each accepted sample and compares
// them with the results that leave the block, oldest first.
// ----------------------------------------------------------------------------
module bda_result_monitor
    import bda_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    // now_ms[31:0], raw_pressed[35:32], zero [39:36]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // fire_mask[3:0], filtered_mask[7:4]
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked,
    output int                     o_pulses
);

    logic [CFG_W-1:0]   settle_limit;
    logic [CFG_W-1:0]   repeat_delay_ms;
    logic [CFG_W-1:0]   repeat_period_ms;
    logic [FIELD_W-1:0] repeat_mask;

    logic [NUM_BUTTONS-1:0] level_q;
    logic [NUM_BUTTONS-1:0] raw_q;
    logic [TIME_W-1:0]      change_stamp [NUM_BUTTONS];
    logic [TIME_W-1:0]      first_stamp  [NUM_BUTTONS];
    logic [TIME_W-1:0]      repeat_stamp [NUM_BUTTONS];

    // Expected results packed as on the output bus: filtered over fire.
    logic [OUT_TDATA_W-1:0] expected_masks [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_pulses     = 0;
    end

    // Advances every lane by one sample and returns {filtered, fire}.
    function automatic logic [OUT_TDATA_W-1:0] debounce_sample(
        input logic [TIME_W-1:0]  now,
        input logic [FIELD_W-1:0] raw
    );
        logic [FIELD_W-1:0] fire;
        logic [FIELD_W-1:0] level;
        logic               fired;
        logic [TIME_W-1:0]  settled;
        fire  = '0;
        level = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            fired = 1'b0;
            if (raw[b] != raw_q[b]) begin
                change_stamp[b] = now;
            end
            settled = now - change_stamp[b];
            if (settled >= {16'd0, settle_limit}) begin
                if (raw[b] != level_q[b]) begin
                    level_q[b] = raw[b];
                    if (raw[b]) begin
                        fired           = 1'b1;
                        first_stamp[b]  = now;
                        repeat_stamp[b] = now;
                    end
                end
                // A press pulse takes the place of the repeat check.
                if (repeat_mask[b] && level_q[b] && !fired &&
                    (now - first_stamp[b]) >= {16'd0, repeat_delay_ms} &&
                    (now - repeat_stamp[b]) >= {16'd0, repeat_period_ms}) begin
                    fired           = 1'b1;
                    repeat_stamp[b] = now;
                end
            end
            raw_q[b] = raw[b];
            fire[b]  = fired;
            level[b] = level_q[b];
        end
        return {level, fire};
    endfunction

    always @(posedge i_clk) begin
        logic [OUT_TDATA_W-1:0] want;
        logic [FIELD_W-1:0]     want_fire;
        logic [FIELD_W-1:0]     want_level;
        logic [FIELD_W-1:0]     got_fire;
        logic [FIELD_W-1:0]     got_level;
        if (!i_rst_n) begin
            settle_limit     = DEBOUNCE_RESET;
            repeat_delay_ms  = REPEAT_DELAY_RESET;
            repeat_period_ms = REPEAT_PERIOD_RESET;
            repeat_mask      = REPEAT_MASK_RESET;
            level_q          = '0;
            raw_q            = '0;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                change_stamp[b] = '0;
                first_stamp[b]  = '0;
                repeat_stamp[b] = '0;
            end
            expected_masks.delete();
        end else begin
            // The result of an item accepted now is registered before it can leave,
            // so the output side is checked before the new prediction is queued.
            if (i_m_tvalid && i_m_tready) begin
                got_fire  = i_m_tdata[FIELD_W-1:0];
                got_level = i_m_tdata[2*FIELD_W-1:FIELD_W];
                if (expected_masks.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("unexpected result: fire_mask %h filtered_mask %h",
                                 got_fire, got_level);
                    end
                end else begin
                    want       = expected_masks.pop_front();
                    want_fire  = want[FIELD_W-1:0];
                    want_level = want[2*FIELD_W-1:FIELD_W];
                    o_checked++;
                    if (got_fire != want_fire || got_level != want_level) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("result %0d mismatch: fire_mask exp %h got %h, %s",
                                     o_checked, want_fire, got_fire,
                                     $sformatf("filtered_mask exp %h got %h",
                                               want_level, got_level));
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_DEBOUNCE_TIME: settle_limit     = i_cfg_data;
                    REG_REPEAT_DELAY:  repeat_delay_ms  = i_cfg_data;
                    REG_REPEAT_PERIOD: repeat_period_ms = i_cfg_data;
                    REG_REPEAT_MASK:   repeat_mask      = i_cfg_data[FIELD_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                want = debounce_sample(i_s_tdata[TIME_W-1:0],
                                       i_s_tdata[TIME_W+FIELD_W-1:TIME_W]);
                o_pulses += $countones(want[FIELD_W-1:0]);
                expected_masks.push_back(want);
            end
        end
        o_pending = expected_masks.size();
    end

endmodule

/* sim/button_debounce_autorepeat_test.sv */
// ----------------------------------------------------------------------------
// Button debouncer testbench
// Drives timestamped button samples through several timing settings: a
// directed opening, then bounced press, hold and release sequences with
// random timing mixed with noise. Both stream sides idle and stall at random;
// a separate monitor predicts and checks every result.
// ----------------------------------------------------------------------------
module button_debounce_autorepeat_test;
    import bda_pkg::*;

    localparam int HOLD_OFF_CYCLES = 64;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PHASE_ITEMS     = 126;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;

    int fail_count;
    int pending;
    int checked;
    int pulses;

    // Stimulus state: the current timestamp, the raw level last sent and the
    // timing the block was last given.
    logic [TIME_W-1:0]  stamp;
    logic [FIELD_W-1:0] raw_level;
    int unsigned        cur_debounce;
    int unsigned        cur_delay;
    int unsigned        cur_period;
    int                 samples_sent;
    int                 settings_used;
    bit                 tx_gaps;
    bit                 rx_steady;
    bit                 hold_request;
    int                 quiet_cycles;

    button_debounce_autorepeat uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    bda_result_monitor monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_pulses     (pulses)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    // Nothing moving on any port for too long means the block has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result receiver: random stalls, a steady stretch, and one long hold-off.
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (rx_steady) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= 26);
            end
        end
    end

    task automatic send_sample(input logic [TIME_W-1:0] delta,
                               input logic [FIELD_W-1:0] raw);
        @(negedge i_clk);
        if (tx_gaps && $urandom_range(0, 99) < 26) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge i_clk);
        end
        stamp = stamp + delta;
        raw_level = raw;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_TDATA_W-TIME_W-FIELD_W){1'b0}}, raw, stamp};
        do @(posedge i_clk); while (!o_s_axis_tready);
        samples_sent++;
    endtask

    // Stops offering items and waits until every result has left the block.
    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_timing(input logic [CFG_W-1:0] debounce,
                              input logic [CFG_W-1:0] delay,
                              input logic [CFG_W-1:0] period,
                              input logic [CFG_W-1:0] mask);
        write_reg(REG_DEBOUNCE_TIME, debounce);
        write_reg(REG_REPEAT_DELAY, delay);
        write_reg(REG_REPEAT_PERIOD, period);
        write_reg(REG_REPEAT_MASK, mask);
        cur_debounce = 32'(debounce);
        cur_delay    = 32'(delay);
        cur_period   = 32'(period);
        settings_used++;
    endtask

    // Time steps that land on and around the interesting thresholds.
    function automatic logic [TIME_W-1:0] pick_delta();
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return 1;
            2:       return cur_debounce;
            3:       return cur_debounce - 1;
            4:       return cur_debounce + 1;
            5:       return cur_period;
            6:       return cur_delay;
            7:       return $urandom_range(0, 200);
            8:       return $urandom_range(0, 65535);
            9:       return $urandom;
            default: return $urandom_range(0, (cur_delay > cur_period ? cur_delay
                                                                       : cur_period) + 2);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] bounce_delta();
        return $urandom_range(0, cur_debounce > 2 ? cur_debounce : 2);
    endfunction

    // A press with contact bounce, a hold, then a bounced release.
    task automatic press_episode();
        logic [FIELD_W-1:0] target;
        logic [FIELD_W-1:0] pressed;
        logic [FIELD_W-1:0] released;
        target   = FIELD_W'($urandom_range(1, 15));
        pressed  = raw_level | target;
        released = raw_level & ~target;
        repeat ($urandom_range(0, 3)) begin
            send_sample(bounce_delta(),
                        raw_level ^ (target & FIELD_W'($urandom_range(0, 15))));
        end
        send_sample(bounce_delta(), pressed);
        repeat ($urandom_range(3, 10)) send_sample(pick_delta(), pressed);
        repeat ($urandom_range(0, 3)) begin
            send_sample(bounce_delta(),
                        pressed ^ (target & FIELD_W'($urandom_range(0, 15))));
        end
        send_sample(bounce_delta(), released);
        repeat ($urandom_range(1, 3)) send_sample(pick_delta(), released);
    endtask

    task automatic random_phase(input int phase);
        int start;
        start = samples_sent;
        while (samples_sent - start < PHASE_ITEMS) begin
            if (phase == 2 && samples_sent - start >= 40 && samples_sent - start < 45) begin
                hold_request = 1'b1;
            end
            if (phase == 3 && rx_steady && samples_sent - start >= PHASE_ITEMS / 2) begin
                drain();
                tx_gaps   = 1'b1;
                rx_steady = 1'b0;
            end
            if ($urandom_range(0, 4) == 0) begin
                // Noise: a jump anywhere in time with an arbitrary level.
                if ($urandom_range(0, 1) == 0) begin
                    stamp = $urandom;
                end
                send_sample(pick_delta(), FIELD_W'($urandom_range(0, 15)));
            end else begin
                press_episode();
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        quiet_cycles    = 0;
        stamp           = '0;
        raw_level       = '0;
        cur_debounce    = 32'(DEBOUNCE_RESET);
        cur_delay       = 32'(REPEAT_DELAY_RESET);
        cur_period      = 32'(REPEAT_PERIOD_RESET);
        samples_sent    = 0;
        settings_used   = 1;
        tx_gaps         = 1'b1;
        rx_steady       = 1'b0;
        hold_request    = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset timing: settle across the timestamp wrap, first repeat after
        // the delay, one short of the period and on it, bounce while held,
        // then a release.
        send_sample(32'd0, 4'h0);
        send_sample(32'hFFFF_FFFF, 4'hF);
        send_sample(32'd50, 4'hF);
        send_sample(32'd400, 4'hF);
        send_sample(32'd119, 4'hF);
        send_sample(32'd1, 4'hF);
        send_sample(32'd0, 4'h5);
        send_sample(32'd31, 4'hF);
        send_sample(32'd50, 4'hF);
        send_sample(32'd50, 4'h0);
        send_sample(32'd49, 4'h0);
        send_sample(32'd1, 4'h0);
        send_sample(32'd0, 4'hA);
        send_sample(32'd60, 4'hA);
        drain();

        // All zero timing: the level follows at once and a held button with
        // repeat on fires on every later sample. The mask write carries
        // extra high bits that the register drops.
        set_timing(16'd0, 16'd0, 16'd0, 16'hFFFF);
        send_sample(32'd0, 4'hF);
        send_sample(32'd0, 4'hF);
        send_sample(32'd5, 4'hF);
        send_sample(32'd0, 4'h0);
        send_sample(32'd0, 4'hA);
        send_sample(32'd0, 4'hA);
        send_sample(32'd0, 4'h5);
        random_phase(0);

        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFF0);
        random_phase(1);

        set_timing(CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 40)),
                   CFG_W'($urandom_range(1, 15)), CFG_W'($urandom_range(0, 65535)));
        random_phase(2);

        tx_gaps   = 1'b0;
        rx_steady = 1'b1;
        set_timing(CFG_W'($urandom_range(20, 100)), CFG_W'($urandom_range(100, 600)),
                   CFG_W'($urandom_range(30, 200)), CFG_W'($urandom_range(0, 65535)));
        random_phase(3);

        set_timing(CFG_W'($urandom_range(0, 12)), CFG_W'($urandom_range(0, 60)),
                   CFG_W'($urandom_range(0, 20)), CFG_W'($urandom_range(0, 65535)));
        random_phase(4);

        repeat (5) @(negedge i_clk);
        $display("Sent %0d samples under %0d timing settings; checked %0d results, %0d pulses.",
                 samples_sent, settings_used, checked, pulses);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d results failed", fail_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
design/bda_pkg.sv
design/bda_lane.sv
design/bda_merge.sv
design/button_debounce_autorepeat.sv
design/bda_checker.sv
sim/bda_result_monitor.sv
sim/button_debounce_autorepeat_test.sv
